>>> src/qkh_pkg.sv
package qkh_pkg;

  // fixed field widths
  localparam int KEY_W        = 8;
  localparam int RADDR_W      = 17;
  localparam int HASH_INDEX_W = 20;
  localparam int CFG_W        = 5;
  localparam int WORD_W       = 32;
  localparam int BYTE_W       = 8;

  // register reset and hash constants
  localparam logic [CFG_W-1:0]  IDX_WIDTH_RESET = 5'd20;
  localparam logic [WORD_W-1:0] HASH_MULT       = 32'h4F1B_BCDC;
  localparam logic [BYTE_W-1:0] BYTE_EMPTY      = 8'hFF;

  // item kinds
  localparam logic KIND_KEY  = 1'b0;
  localparam logic KIND_READ = 1'b1;

  // folded keyword or read request, leaving the fold stage
  typedef struct packed {
    logic               valid;
    logic               kind;
    logic [WORD_W-1:0]  word;
    logic [RADDR_W-1:0] raddr;
  } fold_out_t;

  // hashed product or read request, leaving the multiplier stage
  typedef struct packed {
    logic               valid;
    logic               kind;
    logic [WORD_W-1:0]  prod;
    logic [RADDR_W-1:0] raddr;
  } hash_out_t;

  // finished result headed for the output register
  typedef struct packed {
    logic                    valid;
    logic                    is_read_reply;
    logic [HASH_INDEX_W-1:0] hash_index;
    logic                    newly_added;
    logic [BYTE_W-1:0]       table_byte;
  } result_t;

endpackage

>>> src/qkh_fold.sv
module qkh_fold (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         adv,
  input  logic                         in_xfer,
  input  logic                         kind,
  input  logic [qkh_pkg::KEY_W-1:0]    key_byte,
  input  logic                         last_byte,
  input  logic [qkh_pkg::RADDR_W-1:0]  read_address,
  output qkh_pkg::fold_out_t           fold_out
);

  logic [qkh_pkg::WORD_W-1:0] fold_word;
  logic [1:0]                 lane_position;
  logic [qkh_pkg::KEY_W-1:0]  lower_byte;
  logic [qkh_pkg::WORD_W-1:0] fold_next;

  // ascii lower-case, letters only
  always_comb begin
    if (key_byte >= 8'h41 && key_byte <= 8'h5A) begin
      lower_byte = key_byte + 8'h20;
    end else begin
      lower_byte = key_byte;
    end
    fold_next = fold_word ^ ({24'd0, lower_byte} << {lane_position, 3'b000});
  end

  // fold state, cleared at the end of each keyword
  always_ff @(posedge clk) begin
    if (rst) begin
      fold_word     <= '0;
      lane_position <= '0;
    end else if (in_xfer && kind == qkh_pkg::KIND_KEY) begin
      if (last_byte) begin
        fold_word     <= '0;
        lane_position <= '0;
      end else begin
        fold_word     <= fold_next;
        lane_position <= lane_position + 2'd1;
      end
    end
  end

  // stage register: only reads and finished keywords move on
  always_ff @(posedge clk) begin
    if (adv) begin
      fold_out.kind  <= kind;
      fold_out.word  <= fold_next;
      fold_out.raddr <= read_address;
    end
    if (rst) begin
      fold_out.valid <= 1'b0;
    end else if (adv) begin
      fold_out.valid <= in_xfer && (kind == qkh_pkg::KIND_READ || last_byte);
    end
  end

endmodule

>>> src/qkh_hash.sv
module qkh_hash (
  input  logic               clk,
  input  logic               rst,
  input  logic               adv,
  input  qkh_pkg::fold_out_t fold_in,
  output qkh_pkg::hash_out_t hash_out
);

  // multiplier stage, low 32 bits of the product kept
  always_ff @(posedge clk) begin
    if (adv) begin
      hash_out.kind  <= fold_in.kind;
      hash_out.prod  <= fold_in.word * qkh_pkg::HASH_MULT;
      hash_out.raddr <= fold_in.raddr;
    end
    if (rst) begin
      hash_out.valid <= 1'b0;
    end else if (adv) begin
      hash_out.valid <= fold_in.valid;
    end
  end

endmodule

>>> src/qkh_table.sv
module qkh_table #(
  parameter int MAX_HASH_BITS = 20,
  parameter int TABLE_BYTES   = 131072
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        adv,
  input  logic [qkh_pkg::CFG_W-1:0]   idx_width,
  input  qkh_pkg::hash_out_t          hash_in,
  output logic                        clearing,
  output qkh_pkg::result_t            result
);

  localparam int ADDR_W = $clog2(TABLE_BYTES);

  logic [qkh_pkg::BYTE_W-1:0] mem [TABLE_BYTES];

  // clear sweep
  logic [ADDR_W-1:0]          clear_addr;

  // index stage
  logic [qkh_pkg::CFG_W-1:0]  eff_bits;
  logic [5:0]                 shift_amt;
  logic [qkh_pkg::WORD_W-1:0] shifted;
  logic [MAX_HASH_BITS-1:0]   idx;
  logic [qkh_pkg::WORD_W-1:0] byte_addr_w;
  logic [ADDR_W-1:0]          rd_addr;

  // read-modify-write stage
  logic                       s3_valid;
  logic                       s3_kind;
  logic [MAX_HASH_BITS-1:0]   s3_idx;
  logic [ADDR_W-1:0]          s3_addr;
  logic [qkh_pkg::BYTE_W-1:0] rdata;
  logic [qkh_pkg::BYTE_W-1:0] merged;
  logic [qkh_pkg::BYTE_W-1:0] bit_mask;
  logic [qkh_pkg::BYTE_W-1:0] wdata;
  logic                       was_empty;
  logic                       rmw_we;
  logic [qkh_pkg::WORD_W-1:0] idx_w;

  // bypass of the write made at the edge of our read
  logic                       last_wr_valid;
  logic [ADDR_W-1:0]          last_wr_addr;
  logic [qkh_pkg::BYTE_W-1:0] last_wr_data;

  // memory write port
  logic                       mem_we;
  logic [ADDR_W-1:0]          mem_waddr;
  logic [qkh_pkg::BYTE_W-1:0] mem_wdata;

  // fill every byte with the empty pattern after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing   <= 1'b1;
      clear_addr <= '0;
    end else if (clearing) begin
      clear_addr <= clear_addr + 1'b1;
      if (clear_addr == ADDR_W'(TABLE_BYTES - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  // clamp index width, take the top bits of the product; reads use their own raddr
  always_comb begin
    priority if (idx_width == '0) begin
      eff_bits = qkh_pkg::CFG_W'(1);
    end else if (idx_width > qkh_pkg::CFG_W'(MAX_HASH_BITS)) begin
      eff_bits = qkh_pkg::CFG_W'(MAX_HASH_BITS);
    end else begin
      eff_bits = idx_width;
    end
    shift_amt = 6'd32 - {1'b0, eff_bits};
    shifted   = hash_in.prod >> shift_amt;
    idx       = shifted[MAX_HASH_BITS-1:0];
    if (hash_in.kind == qkh_pkg::KIND_READ) begin
      byte_addr_w = qkh_pkg::WORD_W'(hash_in.raddr);
    end else begin
      byte_addr_w = qkh_pkg::WORD_W'(idx) >> 3;
    end
    rd_addr = byte_addr_w[ADDR_W-1:0];
  end

  // index stage to read stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (adv) begin
      s3_valid <= hash_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_kind <= hash_in.kind;
      s3_idx  <= idx;
      s3_addr <= rd_addr;
    end
  end

  // modify: forward a write that landed together with our read
  always_comb begin
    if (last_wr_valid && last_wr_addr == s3_addr) begin
      merged = last_wr_data;
    end else begin
      merged = rdata;
    end
    bit_mask  = qkh_pkg::BYTE_W'(1) << s3_idx[2:0];
    was_empty = (merged & bit_mask) != '0;
    wdata     = merged & ~bit_mask;
    rmw_we    = adv && s3_valid && s3_kind == qkh_pkg::KIND_KEY;
    idx_w     = qkh_pkg::WORD_W'(s3_idx);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_wr_valid <= 1'b0;
    end else if (adv) begin
      last_wr_valid <= rmw_we;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      last_wr_addr <= s3_addr;
      last_wr_data <= wdata;
    end
  end

  // single write port shared by the sweep and the write-back
  always_comb begin
    if (clearing) begin
      mem_we    = 1'b1;
      mem_waddr = clear_addr;
      mem_wdata = qkh_pkg::BYTE_EMPTY;
    end else begin
      mem_we    = rmw_we;
      mem_waddr = s3_addr;
      mem_wdata = wdata;
    end
  end

  // presence table
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (adv) begin
      rdata <= mem[rd_addr];
    end
  end

  // result of the read-modify-write stage
  always_comb begin
    result.valid         = s3_valid;
    result.is_read_reply = s3_kind == qkh_pkg::KIND_READ;
    if (s3_kind == qkh_pkg::KIND_READ) begin
      result.hash_index  = '0;
      result.newly_added = 1'b0;
      result.table_byte  = merged;
    end else begin
      result.hash_index  = idx_w[qkh_pkg::HASH_INDEX_W-1:0];
      result.newly_added = was_empty;
      result.table_byte  = '0;
    end
  end

endmodule

>>> src/qrp_keyword_hash_table_unit.sv
// channel   direction  transfer when           payload
// in        input      in_valid & !in_stall    kind, key_byte, last_byte, read_address
// out       output     out_valid & !out_stall  is_read_reply, hash_index, newly_added,
//                                              table_byte
// cfg       input      cfg_write               cfg_data (index width)
//
// One item per cycle while in_stall is low. Once its last keyword byte or read is taken
// into the fold register, a result reaches the output register by multiply, index and table
// read, and read-modify-write into the output register. Keyword bytes that are not last give
// no result. After reset a sweep writes 0xFF to every table byte, with in_stall high.
// The pipeline moves as one: a held output stalls every stage and the input.
// The user must keep TABLE_BYTES a power of two; the block does not enforce it.
module qrp_keyword_hash_table_unit #(
  parameter int MAX_HASH_BITS = 20,
  parameter int TABLE_BYTES   = 131072
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              kind,
  input  logic [qkh_pkg::KEY_W-1:0]         key_byte,
  input  logic                              last_byte,
  input  logic [qkh_pkg::RADDR_W-1:0]       read_address,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              is_read_reply,
  output logic [qkh_pkg::HASH_INDEX_W-1:0]  hash_index,
  output logic                              newly_added,
  output logic [qkh_pkg::BYTE_W-1:0]        table_byte,
  input  logic                              cfg_write,
  input  logic [qkh_pkg::CFG_W-1:0]         cfg_data
);

  logic                      adv;
  logic                      in_xfer;
  logic                      clearing;
  logic [qkh_pkg::CFG_W-1:0] idx_width;
  qkh_pkg::fold_out_t        fold_out;
  qkh_pkg::hash_out_t        hash_out;
  qkh_pkg::result_t          result;

  // pipeline moves when the output register is free or being taken
  assign adv      = !out_valid || !out_stall;
  assign in_stall = clearing || !adv;
  assign in_xfer  = in_valid && !in_stall;

  // hash width register
  always_ff @(posedge clk) begin
    if (rst) begin
      idx_width <= qkh_pkg::IDX_WIDTH_RESET;
    end else if (cfg_write) begin
      idx_width <= cfg_data;
    end
  end

  qkh_fold u_fold (
    .clk          (clk),
    .rst          (rst),
    .adv          (adv),
    .in_xfer      (in_xfer),
    .kind         (kind),
    .key_byte     (key_byte),
    .last_byte    (last_byte),
    .read_address (read_address),
    .fold_out     (fold_out)
  );

  qkh_hash u_hash (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .fold_in  (fold_out),
    .hash_out (hash_out)
  );

  qkh_table #(
    .MAX_HASH_BITS (MAX_HASH_BITS),
    .TABLE_BYTES   (TABLE_BYTES)
  ) u_table (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .idx_width (idx_width),
    .hash_in   (hash_out),
    .clearing  (clearing),
    .result    (result)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= result.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      is_read_reply <= result.is_read_reply;
      hash_index    <= result.hash_index;
      newly_added   <= result.newly_added;
      table_byte    <= result.table_byte;
    end
  end

endmodule
